### rtl/chi_pkg.sv
// Shared constants and controller/datapath interface types for the cuckoo insert block.
// No dependencies.
package chi_pkg;

  localparam int KEY_W          = 31;
  localparam int KICK_W         = 7;
  localparam int SLOT_OUT_W     = 10;
  localparam int TABLE_SIZE_DEF = 11;
  localparam logic [KICK_W-1:0] KICKS_RESET = 7'd11;

  typedef struct packed {
    logic clr_wr;
    logic key_load;
    logic div2_go;
    logic hash_done;
    logic p1;
    logic p2;
    logic fin_ok1;
    logic fin_ok2;
    logic fin_fail;
  } chi_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic t1_valid;
    logic t2_valid;
    logic kicks_left;
    logic kicks_left_next;
  } chi_sts_t;

endpackage

### rtl/chi_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module chi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/chi_div.sv
// Division by the table size through a reciprocal multiply.
// Depends on chi_pkg.
module chi_div #(
  parameter int TABLE_SIZE = chi_pkg::TABLE_SIZE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [chi_pkg::KEY_W-1:0]         dividend_i,
  output logic                              done_o,
  output logic [chi_pkg::KEY_W-1:0]         quo_o,
  output logic [$clog2(TABLE_SIZE)-1:0]     rem_o
);
  import chi_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int SHIFT  = KEY_W + SLOT_W;
  localparam int PROD_W = 2 * KEY_W + 1;
  // ceil(2^SHIFT / TABLE_SIZE) is exact for every KEY_W-bit dividend
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
  localparam logic [KEY_W:0]   RECIP   = RECIP_WIDE[KEY_W:0];
  localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(TABLE_SIZE);

  logic [KEY_W-1:0]  num_q;
  logic [KEY_W-1:0]  quo_q;
  logic [SLOT_W-1:0] rem_q;
  logic              mul_q;
  logic              sub_q;
  logic              done_q;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  back;
  logic [KEY_W-1:0]  diff;

  assign prod = PROD_W'(num_q) * PROD_W'(RECIP);
  assign back = quo_q * DIVISOR;
  assign diff = num_q - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (mul_q) begin
      quo_q <= KEY_W'(prod >> SHIFT);
    end
    if (sub_q) begin
      rem_q <= diff[SLOT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

### rtl/chi_dp.sv
// Datapath: hash divider, both table RAMs, carried key, round count, result registers.
// Depends on chi_pkg, chi_div, chi_ram.
module chi_dp #(
  parameter int TABLE_SIZE = chi_pkg::TABLE_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  chi_pkg::chi_cmd_t                cmd_i,
  output chi_pkg::chi_sts_t                sts_o,
  input  logic [chi_pkg::KEY_W-1:0]        insert_key_i,
  input  logic                             max_kicks_we_i,
  input  logic [chi_pkg::KICK_W-1:0]       max_kicks_i,
  output logic                             done_o,
  output logic                             status_o,
  output logic                             final_table_o,
  output logic [chi_pkg::SLOT_OUT_W-1:0]   final_slot_o,
  output logic [chi_pkg::KICK_W-1:0]       kick_count_o,
  output logic [chi_pkg::KEY_W-1:0]        dropped_key_o
);
  import chi_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int ENT_W  = 1 + KEY_W + SLOT_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SIZE - 1);

  // Entry: {valid, key, the key's hash into the other table}
  logic [KICK_W-1:0] max_q;
  logic [KICK_W-1:0] rounds_q;
  logic [SLOT_W-1:0] clr_q;
  logic [KEY_W-1:0]  ckey_q;
  logic [SLOT_W-1:0] cs1_q, cs2_q;

  logic              div_start, div_done;
  logic [KEY_W-1:0]  div_dividend, div_quo;
  logic [SLOT_W-1:0] div_rem;

  logic              t1_we, t2_we;
  logic [SLOT_W-1:0] t1_waddr, t2_waddr, t1_raddr, t2_raddr;
  logic [ENT_W-1:0]  t1_wdata, t2_wdata, t1_rdata, t2_rdata;

  logic              done_q;
  logic              status_q, table_q;
  logic [SLOT_W-1:0] slot_q;
  logic [KICK_W-1:0] kicks_q;
  logic [KEY_W-1:0]  drop_q;

  assign div_start    = cmd_i.key_load | cmd_i.div2_go;
  assign div_dividend = cmd_i.key_load ? insert_key_i : div_quo;

  chi_div #(.TABLE_SIZE(TABLE_SIZE)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign t1_we    = cmd_i.clr_wr | cmd_i.p1;
  assign t2_we    = cmd_i.clr_wr | cmd_i.p2;
  assign t1_waddr = cmd_i.clr_wr ? clr_q : cs1_q;
  assign t2_waddr = cmd_i.clr_wr ? clr_q : cs2_q;
  assign t1_wdata = cmd_i.clr_wr ? '0 : {1'b1, ckey_q, cs2_q};
  assign t2_wdata = cmd_i.clr_wr ? '0 : {1'b1, ckey_q, cs1_q};
  assign t1_raddr = cmd_i.p2 ? t2_rdata[SLOT_W-1:0] : cs1_q;
  assign t2_raddr = t1_rdata[SLOT_W-1:0];

  chi_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_SIZE)) u_tab1 (
    .clk_i   (clk_i),
    .we_i    (t1_we),
    .waddr_i (t1_waddr),
    .wdata_i (t1_wdata),
    .raddr_i (t1_raddr),
    .rdata_o (t1_rdata)
  );

  chi_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_SIZE)) u_tab2 (
    .clk_i   (clk_i),
    .we_i    (t2_we),
    .waddr_i (t2_waddr),
    .wdata_i (t2_wdata),
    .raddr_i (t2_raddr),
    .rdata_o (t2_rdata)
  );

  assign sts_o.clr_last        = clr_q == SLOT_LAST;
  assign sts_o.div_done        = div_done;
  assign sts_o.t1_valid        = t1_rdata[ENT_W-1];
  assign sts_o.t2_valid        = t2_rdata[ENT_W-1];
  assign sts_o.kicks_left      = rounds_q < max_q;
  assign sts_o.kicks_left_next = ({1'b0, rounds_q} + 8'd1) < {1'b0, max_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= KICKS_RESET;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (max_kicks_we_i) begin
        max_q <= max_kicks_i;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      done_q <= cmd_i.fin_ok1 | cmd_i.fin_ok2 | cmd_i.fin_fail;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) begin
      ckey_q   <= insert_key_i;
      rounds_q <= '0;
    end
    if (cmd_i.div2_go) begin
      cs1_q <= div_rem;
    end
    if (cmd_i.hash_done) begin
      cs2_q <= div_rem;
    end
    if (cmd_i.p1) begin
      ckey_q <= t1_rdata[ENT_W-2:SLOT_W];
      cs2_q  <= t1_rdata[SLOT_W-1:0];
    end
    if (cmd_i.p2) begin
      ckey_q   <= t2_rdata[ENT_W-2:SLOT_W];
      cs1_q    <= t2_rdata[SLOT_W-1:0];
      rounds_q <= rounds_q + 1'b1;
    end
    if (cmd_i.fin_ok1 || cmd_i.fin_ok2) begin
      status_q <= 1'b0;
      table_q  <= cmd_i.fin_ok2;
      slot_q   <= cmd_i.fin_ok2 ? cs2_q : cs1_q;
      kicks_q  <= rounds_q;
      drop_q   <= '0;
    end
    if (cmd_i.fin_fail) begin
      status_q <= 1'b1;
      table_q  <= 1'b0;
      slot_q   <= '0;
      kicks_q  <= rounds_q;
      drop_q   <= ckey_q;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign final_table_o = table_q;
  assign final_slot_o  = SLOT_OUT_W'(slot_q);
  assign kick_count_o  = kicks_q;
  assign dropped_key_o = drop_q;

endmodule

### rtl/chi_ctrl.sv
// Controller FSM: clearing sweep, hash computation, alternating table probes.
// Depends on chi_pkg.
module chi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  chi_pkg::chi_sts_t sts_i,
  output chi_pkg::chi_cmd_t cmd_o
);
  import chi_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_P1   = 3'd4;
  localparam logic [2:0] S_P2   = 3'd5;
  localparam logic [2:0] S_FAIL = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.key_load = 1'b1;
          state_d        = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.div2_go = 1'b1;
          state_d       = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts_i.div_done) begin
          cmd_o.hash_done = 1'b1;
          state_d         = sts_i.kicks_left ? S_P1 : S_FAIL;
        end
      end
      S_P1: begin
        cmd_o.p1 = 1'b1;
        if (!sts_i.t1_valid) begin
          cmd_o.fin_ok1 = 1'b1;
          state_d       = S_IDLE;
        end else begin
          state_d = S_P2;
        end
      end
      S_P2: begin
        cmd_o.p2 = 1'b1;
        if (!sts_i.t2_valid) begin
          cmd_o.fin_ok2 = 1'b1;
          state_d       = S_IDLE;
        end else begin
          state_d = sts_i.kicks_left_next ? S_P1 : S_FAIL;
        end
      end
      S_FAIL: begin
        cmd_o.fin_fail = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

### rtl/cuckoo_hash_insert_top.sv
// Top level of the two-table cuckoo hash insert block.
// Depends on chi_pkg, chi_ctrl, chi_dp.
//
// Usage:
//   A transaction is accepted on a rising edge with start_i high and busy_o low;
//   insert_key_i is sampled there. max_kicks_i is written on any edge with
//   max_kicks_we_i high; the user must only change it while the block is idle,
//   which the block does not enforce. Each result appears for exactly one cycle
//   with done_o high; the receiver cannot stall it, so it must take it in that
//   cycle. busy_o is low again in the done_o cycle, so the next transaction may
//   start right then.
// Hashing and probes:
//   Both slot hashes come from one reciprocal-multiply divider, run first on the
//   key and then on its quotient. Each table probe uses the registered RAM read
//   port, and a round probes table one, then table two; one insert at a time.
// Reset:
//   rst_ni clears control state and max_kicks to 11, then a clearing pass
//   writes every slot of both tables empty; busy_o stays high during it.
module cuckoo_hash_insert_top #(
  parameter int TABLE_SIZE = chi_pkg::TABLE_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [chi_pkg::KEY_W-1:0]      insert_key_i,
  input  logic                           max_kicks_we_i,
  input  logic [chi_pkg::KICK_W-1:0]     max_kicks_i,
  output logic                           done_o,
  output logic                           status_o,
  output logic                           final_table_o,
  output logic [chi_pkg::SLOT_OUT_W-1:0] final_slot_o,
  output logic [chi_pkg::KICK_W-1:0]     kick_count_o,
  output logic [chi_pkg::KEY_W-1:0]      dropped_key_o
);
  import chi_pkg::*;

  chi_cmd_t cmd;
  chi_sts_t sts;

  chi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  chi_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .insert_key_i   (insert_key_i),
    .max_kicks_we_i (max_kicks_we_i),
    .max_kicks_i    (max_kicks_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .final_table_o  (final_table_o),
    .final_slot_o   (final_slot_o),
    .kick_count_o   (kick_count_o),
    .dropped_key_o  (dropped_key_o)
  );

endmodule

### rtl/chi_chk.sv
// Port-level checker for the cuckoo insert top level, with its bind statement.
// Depends on chi_pkg and cuckoo_hash_insert_top.
module chi_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input logic                           status_o,
  input logic                           final_table_o,
  input logic [chi_pkg::SLOT_OUT_W-1:0] final_slot_o,
  input logic [chi_pkg::KEY_W-1:0]      dropped_key_o
);
  import chi_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> final_table_o == 1'b0 && final_slot_o == '0)
    else $error("failed insert reports a placement");

  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !status_o |-> dropped_key_o == '0)
    else $error("successful insert reports a dropped key");

endmodule

bind cuckoo_hash_insert_top chi_chk u_chk (.*);

### test/testbench.sv
// Self-checking testbench for cuckoo_hash_insert_top: directed and random insert
// transactions checked against a predictor of both tables. Depends on chi_pkg and
// the RTL of cuckoo_hash_insert_top.
module testbench;
  import chi_pkg::*;

  localparam int unsigned SLOTS = TABLE_SIZE_DEF;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 2 * 127 + 100;
  localparam int unsigned KICKS_TOP = 127;

  localparam logic ST_PLACED  = 1'b0;
  localparam logic ST_DROPPED = 1'b1;
  localparam logic TBL_FIRST  = 1'b0;
  localparam logic TBL_SECOND = 1'b1;

  typedef struct packed {
    logic                  status;
    logic                  final_table;
    logic [SLOT_OUT_W-1:0] final_slot;
    logic [KICK_W-1:0]     kick_count;
    logic [KEY_W-1:0]      dropped_key;
  } insert_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [KEY_W-1:0]      insert_key_i = '0;
  logic                  max_kicks_we_i = 1'b0;
  logic [KICK_W-1:0]     max_kicks_i = '0;
  logic                  done_o;
  logic                  status_o;
  logic                  final_table_o;
  logic [SLOT_OUT_W-1:0] final_slot_o;
  logic [KICK_W-1:0]     kick_count_o;
  logic [KEY_W-1:0]      dropped_key_o;

  cuckoo_hash_insert_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .insert_key_i   (insert_key_i),
    .max_kicks_we_i (max_kicks_we_i),
    .max_kicks_i    (max_kicks_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .final_table_o  (final_table_o),
    .final_slot_o   (final_slot_o),
    .kick_count_o   (kick_count_o),
    .dropped_key_o  (dropped_key_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [KEY_W-1:0]  first_key [SLOTS];
  logic              first_vld [SLOTS];
  logic [KEY_W-1:0]  second_key [SLOTS];
  logic              second_vld [SLOTS];
  logic [KICK_W-1:0] kicks_setting = KICKS_RESET;

  insert_result_t   pending_results[$];
  insert_result_t   want;
  logic [KEY_W-1:0] recent_keys[$];
  int unsigned      errors = 0;
  int unsigned      inserts_sent = 0;
  int unsigned      placed_seen = 0;
  int unsigned      dropped_seen = 0;
  int unsigned      kick_writes = 0;
  int unsigned      cycles = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      first_vld[i] = 1'b0;
      second_vld[i] = 1'b0;
    end
  end

  function automatic insert_result_t cuckoo_place(input logic [KEY_W-1:0] key);
    insert_result_t   r;
    logic [KEY_W-1:0] carried;
    logic [KEY_W-1:0] held;
    int unsigned      rounds;
    int unsigned      pos;
    r = '0;
    carried = key;
    rounds = 0;
    while (rounds < kicks_setting) begin
      pos = carried % SLOTS;
      if (!first_vld[pos]) begin
        first_key[pos] = carried;
        first_vld[pos] = 1'b1;
        r.status = ST_PLACED;
        r.final_table = TBL_FIRST;
        r.final_slot = SLOT_OUT_W'(pos);
        r.kick_count = KICK_W'(rounds);
        return r;
      end
      held = first_key[pos];
      first_key[pos] = carried;
      carried = held;
      pos = (carried / SLOTS) % SLOTS;
      if (!second_vld[pos]) begin
        second_key[pos] = carried;
        second_vld[pos] = 1'b1;
        r.status = ST_PLACED;
        r.final_table = TBL_SECOND;
        r.final_slot = SLOT_OUT_W'(pos);
        r.kick_count = KICK_W'(rounds);
        return r;
      end
      held = second_key[pos];
      second_key[pos] = carried;
      carried = held;
      rounds++;
    end
    r.status = ST_DROPPED;
    r.final_table = TBL_FIRST;
    r.kick_count = KICK_W'(rounds);
    r.dropped_key = carried;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint exp_v,
                                      input longint got_v, input logic got_known);
    if (!got_known || exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no insert outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o, !$isunknown(status_o));
        check_field("final_table", want.final_table, final_table_o,
                    !$isunknown(final_table_o));
        check_field("final_slot", want.final_slot, final_slot_o,
                    !$isunknown(final_slot_o));
        check_field("kick_count", want.kick_count, kick_count_o,
                    !$isunknown(kick_count_o));
        check_field("dropped_key", want.dropped_key, dropped_key_o,
                    !$isunknown(dropped_key_o));
        if (status_o === ST_DROPPED) dropped_seen++;
        else placed_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_insert(input logic [KEY_W-1:0] key);
    start_i <= 1'b1;
    insert_key_i <= key;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(cuckoo_place(key));
    inserts_sent++;
    recent_keys.push_back(key);
    if (recent_keys.size() > 16) void'(recent_keys.pop_front());
  endtask

  task automatic drain_results();
    if (start_i) start_i <= 1'b0;
    while (pending_results.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_max_kicks(input logic [KICK_W-1:0] value);
    max_kicks_we_i <= 1'b1;
    max_kicks_i <= value;
    @(posedge clk_i);
    max_kicks_we_i <= 1'b0;
    kicks_setting = value;
    kick_writes++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50 || recent_keys.size() == 0) return KEY_W'($urandom);
    if (sel < 75) return KEY_W'($urandom_range(0, SLOTS * SLOTS * 2));
    return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
  endfunction

  function automatic logic [KICK_W-1:0] pick_kicks();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return KICK_W'(KICKS_TOP);
      2: return KICK_W'(64);
      default: return KICK_W'($urandom_range(1, 16));
    endcase
  endfunction

  // reset value of max_kicks; keys colliding on table one push a chain into table two
  task automatic test_default_kicks();
    drain_results();
    for (int k = 0; k < SLOTS; k++) send_insert(KEY_W'(k * SLOTS));
    send_insert({KEY_W{1'b1}});
    drain_results();
  endtask

  task automatic test_zero_kicks();
    write_max_kicks('0);
    send_insert(KEY_W'(5));
    send_insert({KEY_W{1'b1}});
    drain_results();
  endtask

  task automatic test_kick_extremes();
    write_max_kicks(KICK_W'(KICKS_TOP));
    send_insert(KEY_W'($urandom));
    send_insert('0);
    drain_results();
    write_max_kicks(KICK_W'(1));
    send_insert(KEY_W'($urandom));
    send_insert(KEY_W'(SLOTS * SLOTS));
    drain_results();
    write_max_kicks(KICK_W'(64));
    send_insert(KEY_W'($urandom));
    send_insert({KEY_W{1'b1}});
    drain_results();
  endtask

  task automatic test_random_inserts(input int unsigned idle_pct);
    for (int chunk = 0; chunk < 4; chunk++) begin
      write_max_kicks(pick_kicks());
      for (int n = 0; n < 50; n++) begin
        send_insert(pick_key());
        if ($urandom_range(0, 99) < idle_pct) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, $urandom_range(0, 1) ? 4 : 100)) @(posedge clk_i);
        end
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_kicks();
    test_zero_kicks();
    test_kick_extremes();
    test_random_inserts(36);
    test_random_inserts(65);
    test_random_inserts(0);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d insert transactions: %0d placed, %0d failed with a dropped key",
             inserts_sent, placed_seen, dropped_seen);
    $display("%0d max_kicks writes, zero through 127, with and without sender gaps",
             kick_writes);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
